// File: rtl/r2u_pkg.sv
// Package for the RGB565 to UYVY converter: field widths, register indexes
// and the constant lookup tables built at elaboration. No dependencies.
`default_nettype none

package r2u_pkg;

    localparam int PIXEL_W = 16;
    localparam int WORD_W = 32;
    localparam int COL_W = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 1;
    localparam int COMP_W = 5;
    localparam int WEIGHT_W = 21;
    localparam int SUM_W = WEIGHT_W + 1;
    localparam int VYU_W = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WIDTH = 1'd1;

    localparam logic [COL_W-1:0] ROW_WIDTH_RESET = 12'd320;

    typedef logic [WEIGHT_W-1:0] luma_rom_t [32];
    typedef logic [7:0] byte_rom_t [64];
    typedef logic [7:0] luma_byte_rom_t [32];

    // Rounds to 24 significant bits, ties to even.
    function automatic logic [63:0] round24(input logic [63:0] n);
        int len;
        int drop;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        len = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (n[i])
            begin
                len = i + 1;
            end
        end
        if (len <= 24)
        begin
            return n;
        end
        drop = len - 24;
        q = n >> drop;
        rem = n & ((64'd1 << drop) - 64'd1);
        half = 64'd1 << (drop - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        return q << drop;
    endfunction

    function automatic luma_rom_t build_luma_rom(input logic [63:0] mant, input int e);
        luma_rom_t rom;
        int s;
        logic [63:0] p;
        logic [63:0] q;
        s = e - 16;
        for (int i = 0; i < 32; i++)
        begin
            p = round24(mant * 64'(i));
            q = round24(p + (64'd1 << (s - 1)));
            rom[i] = WEIGHT_W'(q >> s);
        end
        return rom;
    endfunction

    // Indexed by the six-bit two's complement difference.
    function automatic byte_rom_t build_chroma_rom(input logic [63:0] mant);
        byte_rom_t rom;
        int d;
        int mag;
        int t;
        int v;
        for (int k = 0; k < 64; k++)
        begin
            d = (k < 32) ? k : k - 64;
            mag = (d < 0) ? -d : d;
            t = int'(round24(mant * 64'(mag)) >> 21);
            v = ((d < 0) ? -t : t) + 128;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 255)
            begin
                v = 255;
            end
            rom[k] = 8'(v);
        end
        return rom;
    endfunction

    function automatic luma_byte_rom_t build_luma_byte_rom();
        luma_byte_rom_t rom;
        for (int i = 0; i < 32; i++)
        begin
            rom[i] = 8'(16 + (219 * i) / 32);
        end
        return rom;
    endfunction

    localparam luma_rom_t RED_WEIGHT = build_luma_rom(64'd10032775, 25);
    localparam luma_rom_t GREEN_WEIGHT = build_luma_rom(64'd9848226, 24);
    localparam luma_rom_t BLUE_WEIGHT = build_luma_rom(64'd15300821, 27);
    localparam byte_rom_t U_TABLE = build_chroma_rom(64'd9479127);
    localparam byte_rom_t V_TABLE = build_chroma_rom(64'd11962155);
    localparam luma_byte_rom_t LUMA_BYTE = build_luma_byte_rom();

endpackage

`default_nettype wire

// File: rtl/rgb565_to_uyvy_converter.sv
// Top level of the RGB565 to UYVY converter: column tracking, pixel
// conversion and the output register. Depends on r2u_pkg.
`default_nettype none

// Takes one RGB565 pixel per beat and emits packed UYVY words, one per pixel
// in double-width mode or one per pixel pair otherwise, with chroma from the
// even pixel. Conversion is table lookups, a three-term add and two subtracts
// between the input handshake and a single output register, so a pixel is
// accepted in every cycle unless the output word is stalled. Pixels at or
// past the last multiple of four in a row give no word; m_tlast marks the
// last word of each row.
module rgb565_to_uyvy_converter
    import r2u_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [PIXEL_W-1:0]     s_tdata,   // pixel[15:0]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [WORD_W-1:0]           m_tdata,   // uyvy_word[31:0]
    output logic                        m_tlast,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COL_W-1:0]  row_width_reg;
    logic              double_width_reg;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [VYU_W-1:0]  held_reg;
    logic [VYU_W-1:0]  held_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] out_word_next;
    logic              out_last_reg;
    logic              out_last_next;

    logic              accept;
    logic [COL_W-1:0]  width;
    logic [COL_W-1:0]  limit;
    logic [COL_W:0]    col_plus;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [SUM_W-1:0]  luma_sum;
    logic [COMP_W-1:0] luma;
    logic [5:0]        b_diff;
    logic [5:0]        r_diff;
    logic [7:0]        y_byte;
    logic [VYU_W-1:0]  vyu;
    logic              emit;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_word_reg;
    assign m_tlast = out_last_reg;

    always_comb
    begin
        red = s_tdata[15:11];
        green = s_tdata[10:6];
        blue = s_tdata[4:0];
        luma_sum = SUM_W'(RED_WEIGHT[red]) + SUM_W'(GREEN_WEIGHT[green])
                 + SUM_W'(BLUE_WEIGHT[blue]);
        luma = luma_sum[20:16];
        b_diff = {1'b0, blue} - {1'b0, luma};
        r_diff = {1'b0, red} - {1'b0, luma};
        y_byte = LUMA_BYTE[luma];
        vyu = {V_TABLE[r_diff], y_byte, U_TABLE[b_diff]};
    end

    always_comb
    begin
        if (32'(row_width_reg) < MAX_ROW_WIDTH)
        begin
            width = row_width_reg;
        end
        else
        begin
            width = COL_W'(MAX_ROW_WIDTH);
        end
        limit = {width[COL_W-1:2], 2'b00};
        col_plus = {1'b0, column_reg} + 1'b1;
        emit = (column_reg < limit) && (double_width_reg || column_reg[0]);
    end

    always_comb
    begin
        column_next = column_reg;
        held_next = held_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next = out_word_reg;
        out_last_next = out_last_reg;
        if (accept)
        begin
            if (col_plus >= {1'b0, width})
            begin
                column_next = '0;
            end
            else
            begin
                column_next = col_plus[COL_W-1:0];
            end
            if (column_reg < limit && !double_width_reg && !column_reg[0])
            begin
                held_next = vyu;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_last_next = (col_plus == {1'b0, limit});
                if (double_width_reg)
                begin
                    out_word_next = {y_byte, vyu};
                end
                else
                begin
                    out_word_next = {y_byte, held_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            double_width_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_WIDTH:
                begin
                    row_width_reg <= cfg_data;
                end
                REG_DOUBLE_WIDTH:
                begin
                    double_width_reg <= cfg_data[0];
                end
                default:
                begin
                    row_width_reg <= row_width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            held_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg <= column_next;
            held_reg <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire
